// File: rtl/alc_pkg.sv
// Shared constants, types and coefficient tables for the ambient light lux calculation.
`timescale 1ns / 1ps

package alc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_INTEGRATION_MODE = 2'd0;
	localparam logic [1:0] CFG_GAIN_HIGH        = 2'd1;
	localparam logic [1:0] CFG_PACKAGE_CS       = 2'd2;

	// Integration mode codes.
	localparam logic [1:0] MODE_SHORT   = 2'd0;
	localparam logic [1:0] MODE_MEDIUM  = 2'd1;
	localparam logic [1:0] MODE_NOMINAL = 2'd2;

	// Channel scale factors in units of 2^-10.
	localparam int SCALE_W = 19;
	localparam logic [SCALE_W-1:0] SCALE_SHORT   = 19'h07517;
	localparam logic [SCALE_W-1:0] SCALE_MEDIUM  = 19'h00FE7;
	localparam logic [SCALE_W-1:0] SCALE_NOMINAL = 19'h00400;
	localparam int SCALE_SHIFT = 10;
	localparam int GAIN_SHIFT  = 4;

	// Datapath widths.
	localparam int SUM_W   = 17;
	localparam int CH_W    = 22;
	localparam int NUM_W   = 32;
	localparam int COEF_W  = 10;
	localparam int PROD_W  = 32;
	localparam int LUX_W   = 17;
	localparam int SEG_N   = 8;
	localparam int SEG_W   = 3;
	localparam int RATIO_SHIFT = 9;
	localparam int LUX_SHIFT   = 14;
	localparam logic [LUX_W-1:0] LUX_MAX = 17'h1FFFF;

	// One divider stage per quotient bit.
	localparam int DIV_STAGES = NUM_W;

	// Data that rides along with the divider pipeline.
	typedef struct packed {
		logic [CH_W-1:0] ch1;
	} div_tag_t;

	// Segment upper breakpoints of the rounded ratio; the last segment has none.
	function automatic logic [COEF_W-1:0] seg_break(input logic pkg, input logic [SEG_W-1:0] idx);
		logic [COEF_W-1:0] r;
		case ({pkg, idx})
			4'h0: r = 10'h040;
			4'h1: r = 10'h080;
			4'h2: r = 10'h0C0;
			4'h3: r = 10'h100;
			4'h4: r = 10'h138;
			4'h5: r = 10'h19A;
			4'h6: r = 10'h29A;
			4'h8: r = 10'h043;
			4'h9: r = 10'h085;
			4'hA: r = 10'h0C8;
			4'hB: r = 10'h10A;
			4'hC: r = 10'h14D;
			4'hD: r = 10'h19A;
			4'hE: r = 10'h29A;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Segment offsets applied to channel0.
	function automatic logic [COEF_W-1:0] seg_offset(input logic pkg, input logic [SEG_W-1:0] idx);
		logic [COEF_W-1:0] r;
		case ({pkg, idx})
			4'h0: r = 10'h1F2;
			4'h1: r = 10'h214;
			4'h2: r = 10'h23F;
			4'h3: r = 10'h270;
			4'h4: r = 10'h16F;
			4'h5: r = 10'h0D2;
			4'h6: r = 10'h018;
			4'h8: r = 10'h204;
			4'h9: r = 10'h228;
			4'hA: r = 10'h253;
			4'hB: r = 10'h282;
			4'hC: r = 10'h177;
			4'hD: r = 10'h101;
			4'hE: r = 10'h037;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Segment slopes applied to channel1.
	function automatic logic [COEF_W-1:0] seg_slope(input logic pkg, input logic [SEG_W-1:0] idx);
		logic [COEF_W-1:0] r;
		case ({pkg, idx})
			4'h0: r = 10'h1BE;
			4'h1: r = 10'h2D1;
			4'h2: r = 10'h37B;
			4'h3: r = 10'h3FE;
			4'h4: r = 10'h1FC;
			4'h5: r = 10'h0FB;
			4'h6: r = 10'h012;
			4'h8: r = 10'h1AD;
			4'h9: r = 10'h2C1;
			4'hA: r = 10'h363;
			4'hB: r = 10'h3DF;
			4'hC: r = 10'h1DD;
			4'hD: r = 10'h127;
			4'hE: r = 10'h02B;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/alc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
`timescale 1ns / 1ps

module alc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic [alc_pkg::NUM_W-1:0]           num,
	input  logic [alc_pkg::CH_W-1:0]            den,
	input  alc_pkg::div_tag_t                   tag_in,
	output logic                                out_vld,
	output logic [alc_pkg::NUM_W-1:0]           quot,
	output logic [alc_pkg::CH_W-1:0]            den_out,
	output alc_pkg::div_tag_t                   tag_out
);

	localparam int N = alc_pkg::DIV_STAGES;
	localparam int NW = alc_pkg::NUM_W;
	localparam int DW = alc_pkg::CH_W;

	// Each stage holds the partial remainder and a word that shifts numerator
	// bits out at the top while quotient bits enter at the bottom.
	logic              v_s   [N];
	logic [NW-1:0]     nq_s  [N];
	logic [DW-1:0]     rem_s [N];
	logic [DW-1:0]     den_s [N];
	alc_pkg::div_tag_t tag_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              v_prev;
		logic [NW-1:0]     nq_prev;
		logic [DW-1:0]     rem_prev;
		logic [DW-1:0]     den_prev;
		alc_pkg::div_tag_t tag_prev;
		logic [DW:0]       trial;
		logic [DW:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_prev   = in_vld;
			assign nq_prev  = num;
			assign rem_prev = '0;
			assign den_prev = den;
			assign tag_prev = tag_in;
		end else begin : g_next
			assign v_prev   = v_s[k-1];
			assign nq_prev  = nq_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign den_prev = den_s[k-1];
			assign tag_prev = tag_s[k-1];
		end

		// Bring down the next numerator bit and try a subtraction.
		always_comb begin
			trial = {rem_prev, nq_prev[NW-1]};
			diff  = trial - {1'b0, den_prev};
			ge    = (trial >= {1'b0, den_prev});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]  <= {nq_prev[NW-2:0], ge};
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				den_s[k] <= den_prev;
				tag_s[k] <= tag_prev;
			end
		end
	end

	assign out_vld = v_s[N-1];
	assign quot    = nq_s[N-1];
	assign den_out = den_s[N-1];
	assign tag_out = tag_s[N-1];

	// The final remainder must be below a nonzero divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[N-1] && den_s[N-1] != '0) |-> (rem_s[N-1] < den_s[N-1]))
		else $error("divider remainder not below divisor");

endmodule

// File: rtl/ambient_light_lux_calc.sv
// Top level of the two-channel ambient light lux calculation pipeline.
// Order: stage 1, stage 2, the divider, stages 3 to 5; out_valid is the valid bit of stage 5.
// Throughput: one transaction per cycle unless stalled; the 32-stage divider sets the depth.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset: asynchronous, active low; clears all valid bits and sets the registers to
// integration_mode 2, gain_high 0, package_cs 0.
`timescale 1ns / 1ps

module ambient_light_lux_calc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [1:0]                  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [15:0]                 visible_count,
	input  logic [15:0]                 infrared_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [alc_pkg::LUX_W-1:0]   lux
);

	localparam int CW = alc_pkg::CH_W;
	localparam int KW = alc_pkg::COEF_W;
	localparam int PW = alc_pkg::PROD_W;
	localparam int SW = alc_pkg::SCALE_W;

	// Configuration registers.
	logic [1:0] integration_mode_q;
	logic       gain_high_q;
	logic       package_cs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integration_mode_q <= alc_pkg::MODE_NOMINAL;
			gain_high_q        <= 1'b0;
			package_cs_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				alc_pkg::CFG_INTEGRATION_MODE: integration_mode_q <= cfg_data;
				alc_pkg::CFG_GAIN_HIGH:        gain_high_q        <= cfg_data[0];
				alc_pkg::CFG_PACKAGE_CS:       package_cs_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless a finished result is waiting.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: rebuild channel0 and pick the scale factor.
	logic [SW-1:0] base_c;
	logic [SW-1:0] scale_c;

	always_comb begin
		case (integration_mode_q)
			alc_pkg::MODE_SHORT:  base_c = alc_pkg::SCALE_SHORT;
			alc_pkg::MODE_MEDIUM: base_c = alc_pkg::SCALE_MEDIUM;
			default:              base_c = alc_pkg::SCALE_NOMINAL;
		endcase
		scale_c = gain_high_q ? base_c : (base_c << alc_pkg::GAIN_SHIFT);
	end

	logic                      v_s1;
	logic [alc_pkg::SUM_W-1:0] sum_s1;
	logic [15:0]               ir_s1;
	logic [SW-1:0]             scale_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1   <= {1'b0, visible_count} + {1'b0, infrared_count};
			ir_s1    <= infrared_count;
			scale_s1 <= scale_c;
		end
	end

	// Stage 2: scale both channels; products wrap at 32 bits before the shift.
	logic [35:0] prod0_c;
	logic [34:0] prod1_c;

	assign prod0_c = 36'(sum_s1) * 36'(scale_s1);
	assign prod1_c = 35'(ir_s1) * 35'(scale_s1);

	logic          v_s2;
	logic [CW-1:0] ch0_s2;
	logic [CW-1:0] ch1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch0_s2 <= prod0_c[31:alc_pkg::SCALE_SHIFT];
			ch1_s2 <= prod1_c[31:alc_pkg::SCALE_SHIFT];
		end
	end

	// Divider: channel1 shifted up by ten bits over channel0.
	logic                       dv;
	logic [alc_pkg::NUM_W-1:0]  dquot;
	logic [CW-1:0]              dden;
	alc_pkg::div_tag_t          dtag_in;
	alc_pkg::div_tag_t          dtag;

	assign dtag_in.ch1 = ch1_s2;

	alc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (v_s2),
		.num     ({ch1_s2, (alc_pkg::RATIO_SHIFT + 1)'(0)}),
		.den     (ch0_s2),
		.tag_in  (dtag_in),
		.out_vld (dv),
		.quot    (dquot),
		.den_out (dden),
		.tag_out (dtag)
	);

	// Stage 3: round the ratio and select the segment coefficients.
	logic [alc_pkg::NUM_W-1:0]   rinc_c;
	logic [alc_pkg::NUM_W-2:0]   ratio_c;
	logic [KW-1:0]               off_c;
	logic [KW-1:0]               slp_c;

	always_comb begin
		rinc_c  = dquot + alc_pkg::NUM_W'(1);
		ratio_c = (dden == '0) ? '0 : rinc_c[alc_pkg::NUM_W-1:1];
		off_c   = '0;
		slp_c   = '0;
		for (int s = alc_pkg::SEG_N - 2; s >= 0; s--) begin
			if (ratio_c <= (alc_pkg::NUM_W - 1)'(alc_pkg::seg_break(package_cs_q,
					alc_pkg::SEG_W'(s)))) begin
				off_c = alc_pkg::seg_offset(package_cs_q, alc_pkg::SEG_W'(s));
				slp_c = alc_pkg::seg_slope(package_cs_q, alc_pkg::SEG_W'(s));
			end
		end
	end

	logic          v_s3;
	logic [KW-1:0] off_s3;
	logic [KW-1:0] slp_s3;
	logic [CW-1:0] ch0_s3;
	logic [CW-1:0] ch1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s3 <= off_c;
			slp_s3 <= slp_c;
			ch0_s3 <= dden;
			ch1_s3 <= dtag.ch1;
		end
	end

	// Stage 4: weight each channel by its coefficient.
	logic          v_s4;
	logic [PW-1:0] p0_s4;
	logic [PW-1:0] p1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s4 <= {10'b0, ch0_s3} * {22'b0, off_s3};
			p1_s4 <= {10'b0, ch1_s3} * {22'b0, slp_s3};
		end
	end

	// Stage 5: clamp the difference at zero, round, and saturate.
	logic [PW-1:0]                     diff_c;
	logic [PW-1:0]                     rnd_c;
	logic [PW-alc_pkg::LUX_SHIFT-1:0]  luxw_c;

	always_comb begin
		diff_c = (p1_s4 > p0_s4) ? '0 : (p0_s4 - p1_s4);
		rnd_c  = diff_c + PW'(1 << (alc_pkg::LUX_SHIFT - 1));
		luxw_c = rnd_c[PW-1:alc_pkg::LUX_SHIFT];
	end

	logic                      v_s5;
	logic [alc_pkg::LUX_W-1:0] lux_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lux_s5 <= (luxw_c > (PW - alc_pkg::LUX_SHIFT)'(alc_pkg::LUX_MAX)) ?
				alc_pkg::LUX_MAX : luxw_c[alc_pkg::LUX_W-1:0];
		end
	end

	assign out_valid = v_s5;
	assign lux       = lux_s5;

	// Input backpressure comes only from a waiting result.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without an output stall");

	// A zero channel0 always selects the first segment.
	a_zero_ch0_first_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv && dden == '0) |=>
		(off_s3 == alc_pkg::seg_offset($past(package_cs_q), '0)))
		else $error("zero channel0 did not select the first segment");

	// A negative difference must give zero lux.
	a_negative_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4 && p1_s4 > p0_s4) |=> (lux_s5 == '0))
		else $error("negative difference did not clamp to zero");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the ambient light lux calculation pipeline.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 7;
	localparam int DRAIN_CYCLES    = 48;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int ITEMS_PER_PHASE = 100;

	// Mode code three is not named in the package; the block treats it as nominal.
	localparam logic [1:0] MODE_NOMINAL_ALIAS = 2'd3;
	localparam logic       GAIN_1X            = 1'b0;
	localparam logic       GAIN_16X           = 1'b1;
	localparam logic       PKG_STANDARD       = 1'b0;
	localparam logic       PKG_CS             = 1'b1;

	typedef struct packed {
		bit [15:0] vis;
		bit [15:0] ir;
	} sample_t;

	typedef struct packed {
		bit [31:0] offset;
		bit [31:0] slope;
	} coeff_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         cfg_we         = 1'b0;
	logic [1:0]                   cfg_index      = alc_pkg::CFG_INTEGRATION_MODE;
	logic [1:0]                   cfg_data       = 2'b00;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic [15:0]                  visible_count  = 16'h0000;
	logic [15:0]                  infrared_count = 16'h0000;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic [alc_pkg::LUX_W-1:0]    lux;

	// Shadow copy of the configuration registers.
	bit [1:0]             cfg_mode = alc_pkg::MODE_NOMINAL;
	bit                   cfg_gain = GAIN_1X;
	bit                   cfg_pkg  = PKG_STANDARD;

	sample_t                      pending_samples[$];
	bit [alc_pkg::LUX_W-1:0]      expected_lux[$];
	sample_t                      cur_sample;
	bit [alc_pkg::LUX_W-1:0]      want_lux;
	logic [1:0]                   mode_order [0:3];
	logic                         in_fire = 1'b0;

	int errors       = 0;
	int results_seen = 0;
	int samples_sent = 0;
	int settings_run = 1;
	int idle_cycles  = 0;
	int gap_left     = 0;
	int src_calm     = 0;
	int stall_left   = 0;
	int sink_calm    = 0;

	ambient_light_lux_calc u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.visible_count  (visible_count),
		.infrared_count (infrared_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.lux            (lux)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Offset and slope of the segment that holds the rounded ratio; zero past the last one.
	function automatic coeff_t segment_coeffs(input bit pkg, input bit [31:0] ratio);
		coeff_t c;
		if (pkg == PKG_STANDARD) begin
			if (ratio <= 32'h0040)      c = '{32'h01F2, 32'h01BE};
			else if (ratio <= 32'h0080) c = '{32'h0214, 32'h02D1};
			else if (ratio <= 32'h00C0) c = '{32'h023F, 32'h037B};
			else if (ratio <= 32'h0100) c = '{32'h0270, 32'h03FE};
			else if (ratio <= 32'h0138) c = '{32'h016F, 32'h01FC};
			else if (ratio <= 32'h019A) c = '{32'h00D2, 32'h00FB};
			else if (ratio <= 32'h029A) c = '{32'h0018, 32'h0012};
			else                        c = '{32'h0000, 32'h0000};
		end else begin
			if (ratio <= 32'h0043)      c = '{32'h0204, 32'h01AD};
			else if (ratio <= 32'h0085) c = '{32'h0228, 32'h02C1};
			else if (ratio <= 32'h00C8) c = '{32'h0253, 32'h0363};
			else if (ratio <= 32'h010A) c = '{32'h0282, 32'h03DF};
			else if (ratio <= 32'h014D) c = '{32'h0177, 32'h01DD};
			else if (ratio <= 32'h019A) c = '{32'h0101, 32'h0127};
			else if (ratio <= 32'h029A) c = '{32'h0037, 32'h002B};
			else                        c = '{32'h0000, 32'h0000};
		end
		return c;
	endfunction

	// Expected lux for one sample; every intermediate wraps at 32 bits.
	function automatic bit [alc_pkg::LUX_W-1:0] predict_lux(input bit [15:0] vis,
		input bit [15:0] ir, input bit [1:0] mode, input bit gain, input bit pkg);
		bit [31:0] scale;
		bit [31:0] sum;
		bit [31:0] wide;
		bit [31:0] ch0;
		bit [31:0] ch1;
		bit [31:0] raw_ratio;
		bit [31:0] ratio;
		bit [31:0] p0;
		bit [31:0] p1;
		bit [31:0] diff;
		coeff_t    c;
		case (mode)
			alc_pkg::MODE_SHORT:  scale = 32'h7517;
			alc_pkg::MODE_MEDIUM: scale = 32'h0FE7;
			default:              scale = 32'h0400;
		endcase
		if (gain == GAIN_1X) scale = scale << 4;
		sum  = {16'h0000, vis} + {16'h0000, ir};
		wide = sum * scale;
		ch0  = wide >> 10;
		wide = {16'h0000, ir} * scale;
		ch1  = wide >> 10;
		// A zero channel0 selects the first segment.
		raw_ratio = 32'd0;
		if (ch0 != 32'd0) begin
			wide      = ch1 << 10;
			raw_ratio = wide / ch0;
		end
		ratio = (raw_ratio + 32'd1) >> 1;
		c     = segment_coeffs(pkg, ratio);
		p0    = ch0 * c.offset;
		p1    = ch1 * c.slope;
		diff  = (p1 > p0) ? 32'd0 : (p0 - p1);
		diff  = diff + 32'd8192;
		wide  = diff >> 14;
		if (wide > {15'd0, alc_pkg::LUX_MAX}) wide = {15'd0, alc_pkg::LUX_MAX};
		return wide[alc_pkg::LUX_W-1:0];
	endfunction

	// Idle length: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		else if (r < 95) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	// Random 32-bit value, shifted down by a random amount; the low 16 bits are returned.
	function automatic bit [15:0] rand_field(input int max_shift);
		bit [31:0] r;
		r = $urandom;
		r = r >> $urandom_range(0, max_shift);
		return r[15:0];
	endfunction

	function automatic bit [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0:       return 16'h0000;
			1:       return 16'h0001;
			2:       return 16'h7FFF;
			3:       return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Random sample drawn from one of several shapes.
	function automatic sample_t random_sample();
		sample_t s;
		int      kind;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			s.vis = rand_field(0);
			s.ir  = rand_field(0);
		end else if (kind < 6) begin
			s.vis = 16'($urandom_range(0, 63));
			s.ir  = 16'($urandom_range(0, 63));
		end else if (kind < 9) begin
			s.vis = rand_field(15);
			s.ir  = rand_field(15);
		end else begin
			s.vis = pick_extreme();
			s.ir  = pick_extreme();
		end
		return s;
	endfunction

	task automatic queue_sample(input bit [15:0] vis, input bit [15:0] ir);
		sample_t s;
		s.vis = vis;
		s.ir  = ir;
		pending_samples.push_back(s);
	endtask

	// With a total of 512 the rounded ratio equals the infrared count: land on and past a breakpoint.
	task automatic queue_breakpoint_pair(input bit [15:0] bp);
		queue_sample(16'd512 - bp, bp);
		queue_sample(16'd511 - bp, bp + 16'd1);
	endtask

	// Block until every queued sample has been taken and every result has come back.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_lux.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_config(input bit [1:0] mode, input bit gain, input bit pkg);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= alc_pkg::CFG_INTEGRATION_MODE;
		cfg_data  <= mode;
		@(negedge clk);
		cfg_index <= alc_pkg::CFG_GAIN_HIGH;
		cfg_data  <= {1'b0, gain};
		@(negedge clk);
		cfg_index <= alc_pkg::CFG_PACKAGE_CS;
		cfg_data  <= {1'b0, pkg};
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_mode = mode;
		cfg_gain = gain;
		cfg_pkg  = pkg;
	endtask

	// Stimulus sequence: reset, directed samples, then random samples under every setting.
	initial begin
		mode_order[0] = alc_pkg::MODE_SHORT;
		mode_order[1] = alc_pkg::MODE_MEDIUM;
		mode_order[2] = alc_pkg::MODE_NOMINAL;
		mode_order[3] = MODE_NOMINAL_ALIAS;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Field extremes and a zero channel0 under the reset setting.
		queue_sample(16'h0000, 16'h0000);
		queue_sample(16'hFFFF, 16'hFFFF);
		queue_sample(16'hFFFF, 16'h0000);
		queue_sample(16'h0000, 16'hFFFF);
		queue_sample(16'h0001, 16'h0000);
		queue_sample(16'h0000, 16'h0001);
		queue_breakpoint_pair(16'h0040);
		queue_breakpoint_pair(16'h0080);
		queue_breakpoint_pair(16'h00C0);
		queue_breakpoint_pair(16'h0100);
		queue_breakpoint_pair(16'h0138);
		queue_breakpoint_pair(16'h019A);
		repeat (ITEMS_PER_PHASE) begin
			cur_sample = random_sample();
			pending_samples.push_back(cur_sample);
		end

		for (int m = 0; m < 4; m++) begin
			for (int g = 0; g < 2; g++) begin
				for (int p = 0; p < 2; p++) begin
					wait_idle();
					write_config(mode_order[m], (g == 0) ? GAIN_1X : GAIN_16X,
						(p == 0) ? PKG_STANDARD : PKG_CS);
					settings_run++;
					// The short mode at 1x gain is one of the settings where the channel scaling wraps.
					if (mode_order[m] == alc_pkg::MODE_SHORT && g == 0) begin
						queue_sample(16'd956, 16'd8000);
						queue_sample(16'd0, 16'd9000);
						queue_sample(16'd8955, 16'd0);
						queue_sample(16'hFFFF, 16'h0000);
						queue_sample(16'h8000, 16'h8000);
					end
					repeat (ITEMS_PER_PHASE) begin
						cur_sample = random_sample();
						pending_samples.push_back(cur_sample);
					end
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d lux results for %0d samples under %0d register settings,",
			results_seen, samples_sent, settings_run);
		$display("covering every integration mode, both gains and both coefficient tables.");
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// Input driver: presents queued samples with random gaps between transactions.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					cur_sample = pending_samples.pop_front();
					visible_count  <= cur_sample.vis;
					infrared_count <= cur_sample.ir;
					in_valid       <= 1'b1;
					if (src_calm > 0) src_calm--;
					else if ($urandom_range(0, 2) == 0) gap_left = idle_len();
					else if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 100);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output back-pressure: random stalls, with calm stretches in between.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (sink_calm > 0) sink_calm--;
				else if ($urandom_range(0, 5) == 0) stall_left = idle_len();
				else if ($urandom_range(0, 39) == 0) sink_calm = $urandom_range(20, 100);
			end
		end
	end

	// Monitor: checks each result transaction, then records the expectation for each new sample.
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_lux.size() == 0) begin
					$error("lux result %0d arrived with no sample outstanding", lux);
					errors++;
				end else begin
					want_lux = expected_lux.pop_front();
					if (lux !== want_lux) begin
						$error("field lux: expected %0d, actual %0d", want_lux, lux);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				samples_sent++;
				expected_lux.push_back(predict_lux(visible_count, infrared_count,
					cfg_mode, cfg_gain, cfg_pkg));
			end

			// Watchdog on cycles without any transaction.
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

endmodule
